FILE: design/sprite_sort_and_batch_assert.svh
// Assertion macros for the sprite sort and batch block.
// Used by the port checker; expects clk and rst in the enclosing scope.
`ifndef SPRITE_SORT_AND_BATCH_ASSERT_SVH
`define SPRITE_SORT_AND_BATCH_ASSERT_SVH

// Same-cycle implication checked at every rising edge outside reset.
`define SSB_ASSERT_IMP(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication checked at every rising edge outside reset.
`define SSB_ASSERT_NXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: design/ssb_pkg.sv
// Shared types, constants and the sort comparison for the sprite sort and batch block.
// No dependencies.
`timescale 1ns / 1ps

package ssb_pkg;

  localparam int MAX_SPRITES      = 64;
  localparam int VERTS_PER_SPRITE = 6;
  localparam int SLOT_W           = 6;
  localparam int TEX_W            = 16;
  localparam int DEPTH_W          = 16;
  localparam int VERT_W           = 9;
  localparam int MODE_W           = 2;

  localparam logic [MODE_W-1:0] MODE_DEPTH_DESC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEPTH_ASC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEX_ASC    = 2'd2;

  typedef struct packed {
    logic        [TEX_W-1:0]   tex;
    logic signed [DEPTH_W-1:0] depth;
  } key_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TEX_W-1:0]  tex;
  } order_t;

  // True when sprite a must be drawn strictly ahead of sprite b.
  function automatic logic goes_before(logic [MODE_W-1:0] mode, key_t a, key_t b);
    logic res;
    case (mode)
      MODE_DEPTH_DESC: res = (a.depth > b.depth);
      MODE_DEPTH_ASC:  res = (a.depth < b.depth);
      MODE_TEX_ASC:    res = (a.tex < b.tex);
      default:         res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

FILE: design/sprite_sort_and_batch.sv
// Top level of the sprite sort and batch block: key memory, order memory and sequencer.
// Depends on ssb_pkg.
`timescale 1ns / 1ps

// Usage:
// A sprite request is taken on a rising edge with start high and busy low; sprites may
// arrive back to back while the set loads. The request with last_sprite high closes
// the set (sprites beyond MAX_SPRITES are dropped, but a dropped last sprite still
// closes the set) and raises busy.
// The block then ranks every held sprite against all others through the key memory's one
// read port, and writes each sprite to its sorted place in the order memory.
// Results follow in sorted order, each shown with result_strobe high. Each draw batch
// is scanned once to learn its length and read again to emit it. busy falls in the cycle
// that shows the result with last_result high, and the next set may load from then on.
// The receiver cannot stall; results are never held back.
// Reset clears the held set, the sequencer and sort_mode (depth descending).
// cfg_we writes sort_mode from cfg_data; write it only while busy is low and no set is
// partly loaded.

module sprite_sort_and_batch #(
  parameter int MAX_SPRITES = ssb_pkg::MAX_SPRITES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ssb_pkg::TEX_W-1:0]            texture_id,
  input  logic signed [ssb_pkg::DEPTH_W-1:0]   depth_key,
  input  logic                                 last_sprite,
  input  logic                                 cfg_we,
  input  logic [ssb_pkg::MODE_W-1:0]           cfg_data,
  output logic                                 result_strobe,
  output logic [ssb_pkg::SLOT_W-1:0]           source_slot,
  output logic [ssb_pkg::TEX_W-1:0]            texture_out,
  output logic                                 batch_start,
  output logic [ssb_pkg::VERT_W-1:0]           batch_offset,
  output logic [ssb_pkg::VERT_W-1:0]           batch_vertices,
  output logic                                 last_result
);

  localparam int AW = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
  localparam int CW = AW + 1;

  typedef enum logic [5:0] {
    ST_LOAD      = 6'b000001,
    ST_RANK_LOAD = 6'b000010,
    ST_RANK_HOLD = 6'b000100,
    ST_RANK_SCAN = 6'b001000,
    ST_RUN_SCAN  = 6'b010000,
    ST_EMIT      = 6'b100000
  } state_t;

  state_t                     state, state_next;
  logic [CW-1:0]              total, total_next;
  logic [AW-1:0]              ri, ri_next;
  logic [CW-1:0]              ptr, ptr_next;
  logic                       rd_vld, rd_vld_next;
  logic [AW-1:0]              rd_idx, rd_idx_next;
  logic [CW-1:0]              rank, rank_next;
  ssb_pkg::key_t              key_i, key_i_next;
  logic [CW-1:0]              run_start, run_start_next;
  logic [CW-1:0]              run_end, run_end_next;
  logic [ssb_pkg::TEX_W-1:0]  run_tex, run_tex_next;
  logic [ssb_pkg::MODE_W-1:0] sort_mode;

  ssb_pkg::key_t              key_mem [MAX_SPRITES];
  ssb_pkg::order_t            ord_mem [MAX_SPRITES];
  ssb_pkg::key_t              key_rd;
  ssb_pkg::order_t            ord_rd;

  logic                       key_we;
  logic [AW-1:0]              key_raddr;
  ssb_pkg::key_t              key_wdata;
  logic                       ord_we;
  logic [AW-1:0]              ord_waddr;
  ssb_pkg::order_t            ord_wdata;

  logic                       accept;
  logic                       issue;
  logic [CW-1:0]              issue_limit;
  logic                       idx_last;
  logic                       idx_first;
  logic                       before_ji;
  logic                       before_ij;
  logic                       rank_inc;
  logic [CW-1:0]              rank_sum;
  logic                       tex_break;
  logic                       out_load;

  assign busy      = (state != ST_LOAD);
  assign accept    = start && !busy;
  assign key_we    = accept && (total < CW'(MAX_SPRITES));
  assign key_wdata = '{tex: texture_id, depth: depth_key};
  assign key_raddr = (state == ST_RANK_LOAD) ? ri : ptr[AW-1:0];

  assign idx_last  = ((CW'(rd_idx) + CW'(1)) == total);
  assign idx_first = (CW'(rd_idx) == run_start);
  assign before_ji = ssb_pkg::goes_before(sort_mode, key_rd, key_i);
  assign before_ij = ssb_pkg::goes_before(sort_mode, key_i, key_rd);
  assign rank_inc  = before_ji || (!before_ij && (rd_idx < ri));
  assign rank_sum  = rank + CW'(rank_inc);
  assign tex_break = !idx_first && (ord_rd.tex != run_tex);

  assign ord_we    = (state == ST_RANK_SCAN) && rd_vld && idx_last;
  assign ord_waddr = rank_sum[AW-1:0];
  assign ord_wdata = '{slot: ssb_pkg::SLOT_W'(ri), tex: key_i.tex};

  assign out_load    = (state == ST_EMIT) && rd_vld;
  assign issue_limit = (state == ST_EMIT) ? run_end : total;
  assign issue       = (ptr < issue_limit);

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[total[AW-1:0]] <= key_wdata;
    end
    key_rd <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rd <= ord_mem[ptr[AW-1:0]];
  end

  always_comb begin
    state_next     = state;
    total_next     = total;
    ri_next        = ri;
    ptr_next       = ptr;
    rd_vld_next    = 1'b0;
    rd_idx_next    = rd_idx;
    rank_next      = rank;
    key_i_next     = key_i;
    run_start_next = run_start;
    run_end_next   = run_end;
    run_tex_next   = run_tex;
    case (state)
      ST_LOAD: begin
        if (key_we) begin
          total_next = total + CW'(1);
        end
        if (accept && last_sprite) begin
          ri_next    = '0;
          state_next = ST_RANK_LOAD;
        end
      end
      ST_RANK_LOAD: begin
        ptr_next   = '0;
        state_next = ST_RANK_HOLD;
      end
      ST_RANK_HOLD: begin
        key_i_next  = key_rd;
        rank_next   = '0;
        ptr_next    = ptr + CW'(1);
        rd_vld_next = 1'b1;
        rd_idx_next = ptr[AW-1:0];
        state_next  = ST_RANK_SCAN;
      end
      ST_RANK_SCAN: begin
        if (issue) begin
          ptr_next    = ptr + CW'(1);
          rd_vld_next = 1'b1;
          rd_idx_next = ptr[AW-1:0];
        end
        if (rd_vld) begin
          rank_next = rank_sum;
          if (idx_last) begin
            if ((CW'(ri) + CW'(1)) == total) begin
              run_start_next = '0;
              ptr_next       = '0;
              rd_vld_next    = 1'b0;
              state_next     = ST_RUN_SCAN;
            end else begin
              ri_next    = ri + AW'(1);
              state_next = ST_RANK_LOAD;
            end
          end
        end
      end
      ST_RUN_SCAN: begin
        if (issue) begin
          ptr_next    = ptr + CW'(1);
          rd_vld_next = 1'b1;
          rd_idx_next = ptr[AW-1:0];
        end
        if (rd_vld) begin
          if (idx_first) begin
            run_tex_next = ord_rd.tex;
          end
          if (tex_break || idx_last) begin
            run_end_next = tex_break ? CW'(rd_idx) : total;
            ptr_next     = run_start;
            rd_vld_next  = 1'b0;
            state_next   = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (issue) begin
          ptr_next    = ptr + CW'(1);
          rd_vld_next = 1'b1;
          rd_idx_next = ptr[AW-1:0];
        end
        if (rd_vld && ((CW'(rd_idx) + CW'(1)) == run_end)) begin
          rd_vld_next = 1'b0;
          if (run_end == total) begin
            total_next = '0;
            state_next = ST_LOAD;
          end else begin
            run_start_next = run_end;
            ptr_next       = run_end;
            state_next     = ST_RUN_SCAN;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      total         <= '0;
      rd_vld        <= 1'b0;
      sort_mode     <= ssb_pkg::MODE_DEPTH_DESC;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      total         <= total_next;
      rd_vld        <= rd_vld_next;
      result_strobe <= out_load;
      if (cfg_we) begin
        sort_mode <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ri        <= ri_next;
    ptr       <= ptr_next;
    rd_idx    <= rd_idx_next;
    rank      <= rank_next;
    key_i     <= key_i_next;
    run_start <= run_start_next;
    run_end   <= run_end_next;
    run_tex   <= run_tex_next;
    if (out_load) begin
      source_slot    <= ord_rd.slot;
      texture_out    <= ord_rd.tex;
      batch_start    <= idx_first;
      batch_offset   <= ssb_pkg::VERT_W'(run_start) *
                        ssb_pkg::VERT_W'(ssb_pkg::VERTS_PER_SPRITE);
      batch_vertices <= ssb_pkg::VERT_W'(run_end - run_start) *
                        ssb_pkg::VERT_W'(ssb_pkg::VERTS_PER_SPRITE);
      last_result    <= idx_last;
    end
  end

endmodule

FILE: design/ssb_port_checker.sv
// Port-level checker for the sprite sort and batch block, bound to the top level.
// Depends on sprite_sort_and_batch_assert.svh.
`timescale 1ns / 1ps

`include "sprite_sort_and_batch_assert.svh"

module ssb_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       last_sprite,
  input logic       result_strobe,
  input logic [15:0] texture_out,
  input logic       batch_start,
  input logic [8:0] batch_offset,
  input logic [8:0] batch_vertices,
  input logic       last_result
);

  `SSB_ASSERT_NXT(a_last_request_busy, start && !busy && last_sprite, busy, "set not closed")
  `SSB_ASSERT_IMP(a_mid_result_busy, result_strobe && !last_result, busy, "busy dropped early")
  `SSB_ASSERT_IMP(a_final_result_idle, result_strobe && last_result, !busy, "busy held after set")
  `SSB_ASSERT_IMP(a_batch_steady, result_strobe && !batch_start, $past(result_strobe) && texture_out == $past(texture_out) && batch_offset == $past(batch_offset) && batch_vertices == $past(batch_vertices), "batch fields changed inside a batch")

endmodule

bind sprite_sort_and_batch ssb_port_checker u_ssb_port_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .last_sprite    (last_sprite),
  .result_strobe  (result_strobe),
  .texture_out    (texture_out),
  .batch_start    (batch_start),
  .batch_offset   (batch_offset),
  .batch_vertices (batch_vertices),
  .last_result    (last_result)
);
